### rtl/assert_macros.svh
// assert_macros.svh: assertion macros shared by the harmonic tide sum RTL.
// Uses i_clk and i_rst_n of the module that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define HT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle
`define HT_ASSERT_IMPL(lbl, ante, cons, msg) \
    `HT_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define HT_ASSERT(lbl, prop, msg)
`define HT_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

### rtl/htsum_pkg.sv
// htsum_pkg: types, constants and reciprocal tables of the harmonic tide sum.
// No dependencies; used by every module of the block.
package htsum_pkg;

    localparam int MAX_CONSTITUENTS_DEF = 64;
    localparam int MAX_DERIV_DEF        = 4;
    localparam int CFG_W                = 7;
    localparam int SERIES_STEPS         = 7;

    // Opcodes of an input word
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Fixed-point constants
    localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
    localparam logic [63:0] TWO_PI_Q29 = 64'd3373259426;
    localparam logic [63:0] OMEGA_K    = 64'd97149871472559;
    localparam logic [52:0] TERM_CAP   = 53'd1 << 52;
    localparam logic signed [63:0] TIDE_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] TIDE_MIN = -64'sd140737488355328;

    // Reciprocals ceil(2^40/K) of the series divisors, indexed by series step
    localparam logic [63:0] RECIP_NUM = 64'd1 << 40;
    localparam logic [39:0] RECIP_C [8] = '{
        40'd0,
        40'((RECIP_NUM + 64'd1) / 64'd2),
        40'((RECIP_NUM + 64'd11) / 64'd12),
        40'((RECIP_NUM + 64'd29) / 64'd30),
        40'((RECIP_NUM + 64'd55) / 64'd56),
        40'((RECIP_NUM + 64'd89) / 64'd90),
        40'((RECIP_NUM + 64'd131) / 64'd132),
        40'((RECIP_NUM + 64'd181) / 64'd182)
    };
    localparam logic [39:0] RECIP_S [8] = '{
        40'd0,
        40'((RECIP_NUM + 64'd5) / 64'd6),
        40'((RECIP_NUM + 64'd19) / 64'd20),
        40'((RECIP_NUM + 64'd41) / 64'd42),
        40'((RECIP_NUM + 64'd71) / 64'd72),
        40'((RECIP_NUM + 64'd109) / 64'd110),
        40'((RECIP_NUM + 64'd155) / 64'd156),
        40'((RECIP_NUM + 64'd209) / 64'd210)
    };

    typedef struct packed {
        logic               opcode;
        logic [5:0]         slot;
        logic signed [31:0] amplitude;
        logic [47:0]        speed;
        logic [31:0]        phase;
        logic [24:0]        seconds;
        logic [2:0]         deriv_order;
    } t_in_word;

    typedef struct packed {
        logic signed [47:0] tide_value;
        logic               saturated;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] amplitude;
        logic [47:0]        speed;
        logic [31:0]        phase;
    } t_entry;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

### rtl/htsum_mul.sv
// htsum_mul: shared 64x64 unsigned multiplier built from one 32x32 multiplier.
// Four partial products, one per cycle, accumulated into a 128-bit product.
module htsum_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic [63:0]           i_a,
    input  logic [63:0]           i_b,
    output htsum_pkg::t_mul_stat  o_stat,
    output logic [127:0]          o_prod
);
    import htsum_pkg::*;

    logic [63:0]  r_a, r_b;
    logic [1:0]   r_cnt;
    logic         r_issue, r_busy, r_pp_vld, r_pp_last, r_done;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_sh;
    logic [127:0] r_acc;
    logic [31:0]  a_half, b_half;
    logic [127:0] pp_shift;

    // Select the operand halves of the current partial product
    assign a_half = r_cnt[0] ? r_a[63:32] : r_a[31:0];
    assign b_half = r_cnt[1] ? r_b[63:32] : r_b[31:0];

    // Align the registered partial product
    always_comb begin
        case (r_pp_sh)
            2'd0:    pp_shift = {64'd0, r_pp};
            2'd1:    pp_shift = {32'd0, r_pp, 32'd0};
            2'd2:    pp_shift = {r_pp, 64'd0};
            default: pp_shift = '0;
        endcase
    end

    // Control: issue four partial products, then flag done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue   <= 1'b0;
            r_busy    <= 1'b0;
            r_cnt     <= '0;
            r_pp_vld  <= 1'b0;
            r_pp_last <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_pp_vld  <= r_issue;
            r_pp_last <= r_issue && (r_cnt == 2'd3);
            r_done    <= r_pp_vld && r_pp_last;
            if (i_go) begin
                r_issue <= 1'b1;
                r_busy  <= 1'b1;
                r_cnt   <= '0;
            end else begin
                if (r_issue) begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_issue <= 1'b0;
                    end
                end
                if (r_done) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: latch operands, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_pp_vld) begin
            r_acc <= r_acc + pp_shift;
        end
        r_pp    <= a_half * b_half;
        r_pp_sh <= 2'({1'b0, r_cnt[0]} + {1'b0, r_cnt[1]});
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_acc;

endmodule

### rtl/htsum_tab.sv
// htsum_tab: constituent table, one write port and one registered read port.
// Depends on htsum_pkg for the entry type.
module htsum_tab #(
    parameter int DEPTH = htsum_pkg::MAX_CONSTITUENTS_DEF,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  htsum_pkg::t_entry i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output htsum_pkg::t_entry o_rdata
);
    import htsum_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write a slot, read the addressed slot into a register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/harmonic_tide_sum_core.sv
// Harmonic tide sum: a load word writes one constituent slot and returns nothing;
// an evaluate word sums amp * omega^n * cos(angle) over the active slots and
// returns one saturating Q23.24 word, n the clamped order. A load does not
// stall the input. Every product runs through one shared 32x32 multiplier,
// four partial products per 64x64 product, and the sequencer issues one
// product at a time. The block stalls its input for the whole evaluate.
module harmonic_tide_sum_core #(
    parameter int MAX_CONSTITUENTS = htsum_pkg::MAX_CONSTITUENTS_DEF,
    parameter int MAX_DERIV        = htsum_pkg::MAX_DERIV_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  htsum_pkg::t_in_word             i_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output htsum_pkg::t_out_word            o_data,
    input  logic                            i_cfg_we,
    input  logic [htsum_pkg::CFG_W-1:0]     i_cfg_data
);
    import htsum_pkg::*;

`include "assert_macros.svh"

    localparam int AW   = (MAX_CONSTITUENTS > 1) ? $clog2(MAX_CONSTITUENTS) : 1;
    localparam int CNTW = $clog2(MAX_CONSTITUENTS + 1);
    localparam logic [2:0] N_MAX = 3'(MAX_DERIV);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_START = 5'b00100,
        S_CALC  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    typedef enum logic [3:0] {
        ST_ANG, ST_X, ST_Y2, ST_QC, ST_DC, ST_QS, ST_DS,
        ST_SX, ST_OM, ST_PW, ST_AC, ST_TM
    } t_step;

    t_state r_state, n_state;
    t_step  r_step, n_step;
    logic [CFG_W-1:0] r_cfg;
    logic [CNTW-1:0]  r_lim, n_lim, r_idx, n_idx, cnt_lim;
    logic [24:0]      r_t, n_t;
    logic [2:0]       r_n, n_n, r_pw, n_pw, r_k, n_k, n_clamp;
    logic signed [63:0] r_sum, n_sum;
    logic [31:0]      r_ph, n_ph, r_amag, n_amag, r_xmag, n_xmag, r_y2, n_y2;
    logic [31:0]      r_c, n_c, r_s, n_s, r_cmag, n_cmag;
    logic [47:0]      r_spd, n_spd;
    logic             r_aneg, n_aneg, r_xneg, n_xneg, r_neg, n_neg;
    logic [1:0]       r_q, n_q;
    logic [63:0]      r_omega, n_omega, r_p, n_p;
    logic [63:0]      r_op_a, n_op_a, r_op_b, n_op_b;
    logic             r_go, n_go;
    t_out_word        r_out, n_out;
    logic             r_out_vld, n_out_vld;

    logic        in_acc, tab_we;
    t_entry      wr_entry, rd;
    t_mul_stat   mul_stat;
    logic [127:0] prod;
    logic [47:0] ang;
    logic [31:0] a32, qsum, ru, rmag, d, smag, s_new;
    logic [1:0]  q;
    logic [52:0] val;
    logic [63:0] p_nx;

    // Input handshake and table write
    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign tab_we   = in_acc && (i_data.opcode == OP_LOAD)
                      && (10'(i_data.slot) < 10'(MAX_CONSTITUENTS));
    assign wr_entry = '{amplitude: i_data.amplitude, speed: i_data.speed,
                        phase: i_data.phase};
    assign cnt_lim  = (10'(r_cfg) > 10'(MAX_CONSTITUENTS)) ? CNTW'(MAX_CONSTITUENTS)
                                                           : CNTW'(r_cfg);
    assign n_clamp  = (i_data.deriv_order > N_MAX) ? N_MAX : i_data.deriv_order;

    htsum_tab #(.DEPTH(MAX_CONSTITUENTS), .AW(AW)) u_tab (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (AW'(i_data.slot)),
        .i_wdata (wr_entry),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd)
    );

    htsum_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_go),
        .i_a     (r_op_a),
        .i_b     (r_op_b),
        .o_stat  (mul_stat),
        .o_prod  (prod)
    );

    // Result decoding of the shared multiplier
    always_comb begin
        ang   = {r_ph, 16'd0} + prod[47:0] + {r_n[1:0], 46'd0};
        a32   = ang[47:16];
        qsum  = a32 + 32'h2000_0000;
        q     = qsum[31:30];
        ru    = a32 - {q, 30'd0};
        rmag  = ru[31] ? (32'd0 - ru) : ru;
        d     = prod[71:40];
        s_new = ONE_Q30 - d;
        smag  = prod[61:30];
        val   = (|prod[127:114]) ? TERM_CAP : {1'b0, prod[113:62]};
        p_nx  = (|prod[127:96]) ? '1 : prod[95:32];
    end

    // Sequencer: walk the constituents and the steps of each
    always_comb begin
        n_state = r_state;  n_step = r_step;  n_lim = r_lim;  n_idx = r_idx;
        n_t = r_t;  n_n = r_n;  n_pw = r_pw;  n_k = r_k;  n_sum = r_sum;
        n_ph = r_ph;  n_amag = r_amag;  n_xmag = r_xmag;  n_y2 = r_y2;
        n_c = r_c;  n_s = r_s;  n_cmag = r_cmag;  n_spd = r_spd;
        n_aneg = r_aneg;  n_xneg = r_xneg;  n_neg = r_neg;  n_q = r_q;
        n_omega = r_omega;  n_p = r_p;  n_op_a = r_op_a;  n_op_b = r_op_b;
        n_go = 1'b0;  n_out = r_out;  n_out_vld = r_out_vld;

        // Drop the output word once taken
        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_data.opcode == OP_EVAL)) begin
                    n_t     = i_data.seconds;
                    n_n     = n_clamp;
                    n_lim   = cnt_lim;
                    n_idx   = '0;
                    n_sum   = '0;
                    n_state = (cnt_lim == '0) ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                n_state = S_START;
            end
            S_START: begin
                n_ph    = rd.phase;
                n_spd   = rd.speed;
                n_aneg  = rd.amplitude[31];
                n_amag  = rd.amplitude[31] ? (32'd0 - rd.amplitude) : rd.amplitude;
                n_op_a  = 64'(rd.speed);
                n_op_b  = 64'(r_t);
                n_step  = ST_ANG;
                n_go    = 1'b1;
                n_state = S_CALC;
            end
            S_CALC: begin
                if (mul_stat.done) begin
                    n_go = 1'b1;
                    case (r_step)
                        ST_ANG: begin
                            n_q    = q;
                            n_xneg = ru[31];
                            n_op_a = 64'(rmag);
                            n_op_b = TWO_PI_Q29;
                            n_step = ST_X;
                        end
                        ST_X: begin
                            n_xmag = prod[62:31];
                            n_op_a = 64'(prod[62:31]);
                            n_op_b = 64'(prod[62:31]);
                            n_step = ST_Y2;
                        end
                        ST_Y2: begin
                            n_y2   = prod[61:30];
                            n_c    = ONE_Q30;
                            n_s    = ONE_Q30;
                            n_k    = 3'(SERIES_STEPS);
                            n_op_a = 64'(prod[61:30]);
                            n_op_b = 64'(ONE_Q30);
                            n_step = ST_QC;
                        end
                        ST_QC: begin
                            n_op_a = 64'(prod[61:30]);
                            n_op_b = 64'(RECIP_C[r_k]);
                            n_step = ST_DC;
                        end
                        ST_DC: begin
                            n_c    = s_new;
                            n_op_a = 64'(r_y2);
                            n_op_b = 64'(r_s);
                            n_step = ST_QS;
                        end
                        ST_QS: begin
                            n_op_a = 64'(prod[61:30]);
                            n_op_b = 64'(RECIP_S[r_k]);
                            n_step = ST_DS;
                        end
                        ST_DS: begin
                            n_s = s_new;
                            if (r_k == 3'd1) begin
                                n_op_a = 64'(r_xmag);
                                n_op_b = 64'(s_new);
                                n_step = ST_SX;
                            end else begin
                                n_k    = r_k - 3'd1;
                                n_op_a = 64'(r_y2);
                                n_op_b = 64'(r_c);
                                n_step = ST_QC;
                            end
                        end
                        ST_SX: begin
                            // Rotate by the quarter turn
                            case (r_q)
                                2'd0: begin
                                    n_cmag = r_c;
                                    n_neg  = r_aneg;
                                end
                                2'd1: begin
                                    n_cmag = smag;
                                    n_neg  = r_aneg ^ !r_xneg;
                                end
                                2'd2: begin
                                    n_cmag = r_c;
                                    n_neg  = !r_aneg;
                                end
                                default: begin
                                    n_cmag = smag;
                                    n_neg  = r_aneg ^ r_xneg;
                                end
                            endcase
                            n_op_a = 64'(r_spd);
                            n_op_b = OMEGA_K;
                            n_step = ST_OM;
                        end
                        ST_OM: begin
                            n_omega = prod[111:48];
                            n_p     = 64'h1_0000_0000;
                            n_pw    = '0;
                            if (r_n == 3'd0) begin
                                n_op_a = 64'(r_amag);
                                n_op_b = 64'(r_cmag);
                                n_step = ST_AC;
                            end else begin
                                n_op_a = 64'h1_0000_0000;
                                n_op_b = prod[111:48];
                                n_step = ST_PW;
                            end
                        end
                        ST_PW: begin
                            n_p  = p_nx;
                            n_pw = r_pw + 3'd1;
                            if (r_pw + 3'd1 == r_n) begin
                                n_op_a = 64'(r_amag);
                                n_op_b = 64'(r_cmag);
                                n_step = ST_AC;
                            end else begin
                                n_op_a = p_nx;
                                n_op_b = r_omega;
                            end
                        end
                        ST_AC: begin
                            n_op_a = prod[63:0];
                            n_op_b = r_p;
                            n_step = ST_TM;
                        end
                        ST_TM: begin
                            // Accumulate the term, advance to the next slot
                            n_go  = 1'b0;
                            n_sum = r_neg ? (r_sum - $signed(64'(val)))
                                          : (r_sum + $signed(64'(val)));
                            n_idx = r_idx + 1'b1;
                            n_state = (CNTW'(r_idx + 1'b1) == r_lim) ? S_DONE : S_READ;
                        end
                        default: begin
                            n_go    = 1'b0;
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_DONE: begin
                // Clamp and hand over once the output register is free
                if (!r_out_vld || !i_stall) begin
                    if (r_sum > TIDE_MAX) begin
                        n_out.tide_value = TIDE_MAX[47:0];
                        n_out.saturated  = 1'b1;
                    end else if (r_sum < TIDE_MIN) begin
                        n_out.tide_value = TIDE_MIN[47:0];
                        n_out.saturated  = 1'b1;
                    end else begin
                        n_out.tide_value = r_sum[47:0];
                        n_out.saturated  = 1'b0;
                    end
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= '0;
            r_go      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_go      <= n_go;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_step <= n_step;  r_lim <= n_lim;  r_idx <= n_idx;  r_t <= n_t;
        r_n <= n_n;  r_pw <= n_pw;  r_k <= n_k;  r_sum <= n_sum;
        r_ph <= n_ph;  r_amag <= n_amag;  r_xmag <= n_xmag;  r_y2 <= n_y2;
        r_c <= n_c;  r_s <= n_s;  r_cmag <= n_cmag;  r_spd <= n_spd;
        r_aneg <= n_aneg;  r_xneg <= n_xneg;  r_neg <= n_neg;  r_q <= n_q;
        r_omega <= n_omega;  r_p <= n_p;  r_op_a <= n_op_a;  r_op_b <= n_op_b;
        r_out <= n_out;
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    `HT_ASSERT_IMPL(a_go_idle, r_go, !mul_stat.busy, "multiplier started while busy")
    `HT_ASSERT_IMPL(a_idx_lim, r_state == S_READ, r_idx < r_lim, "slot index past count")
    `HT_ASSERT_IMPL(a_sat_edge, o_valid && o_data.saturated,
        (o_data.tide_value == TIDE_MAX[47:0]) || (o_data.tide_value == TIDE_MIN[47:0]),
        "saturated word not at range edge")
    `HT_ASSERT_IMPL(a_out_src, $rose(o_valid), $past(r_state == S_DONE),
        "output word without finished sum")

endmodule
